### design/pqb_pkg.sv
`timescale 1ns / 1ps

package pqb_pkg;

  localparam int DEPTH  = 16;
  localparam int LEVELS = 5;

  localparam int DATA_W = 32;
  localparam int LVL_W  = 3;
  localparam int STAT_W = 2;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // one queue entry as seen by a neighboring cell
  typedef struct packed {
    logic                     used;
    logic [LVL_W-1:0]         level;
    logic signed [DATA_W-1:0] data;
  } pqb_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic [LVL_W-1:0]         level;
    logic signed [DATA_W-1:0] data;
  } pqb_cmd_t;

endpackage

### design/pqb_if.sv
`timescale 1ns / 1ps

interface pqb_in_if import pqb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [DATA_W-1:0] data_in;
  logic [LVL_W-1:0]         level_in;

  modport source (output valid, opcode, data_in, level_in, input ready);
  modport sink   (input valid, opcode, data_in, level_in, output ready);
endinterface

interface pqb_out_if import pqb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [LVL_W-1:0]         level_out;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         held_after;

  modport source (output valid, data_out, level_out, status, held_after, input ready);
  modport sink   (input valid, data_out, level_out, status, held_after, output ready);
endinterface

### design/pqb_cell.sv
`timescale 1ns / 1ps

module pqb_cell import pqb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pqb_cmd_t   cmd,
  input  pqb_entry_t left_ent,
  input  logic       left_disp,
  input  pqb_entry_t right_ent,
  output pqb_entry_t ent,
  output logic       disp
);

  logic                     used_r, used_nxt;
  logic [LVL_W-1:0]         level_r, level_nxt;
  logic signed [DATA_W-1:0] data_r, data_nxt;

  // entries sit sorted by level, oldest first within a level; an equal
  // level stays ahead of the new entry
  assign disp = !used_r || (level_r < cmd.level);

  always_comb begin
    used_nxt  = used_r;
    level_nxt = level_r;
    data_nxt  = data_r;
    if (cmd.enq) begin
      if (left_disp) begin
        used_nxt  = left_ent.used;
        level_nxt = left_ent.level;
        data_nxt  = left_ent.data;
      end else if (disp) begin
        used_nxt  = 1'b1;
        level_nxt = cmd.level;
        data_nxt  = cmd.data;
      end
    end else if (cmd.deq) begin
      used_nxt  = right_ent.used;
      level_nxt = right_ent.level;
      data_nxt  = right_ent.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    data_r  <= data_nxt;
  end

  assign ent.used  = used_r;
  assign ent.level = level_r;
  assign ent.data  = data_r;

endmodule

### design/priority_queue_bounded.sv
`timescale 1ns / 1ps
// channel | modport | beat contents
// in_if   | sink    | opcode, data_in, level_in
// out_if  | source  | data_out, level_out, status, held_after
//
// One beat per cycle: the cells update in the cycle an item is taken,
// and the result sits in an output register the next cycle.
// in_if.ready stays high while out_if is empty or being taken.
// A stall on out_if holds the result and blocks in_if until it drains.
// Synchronous active-low reset empties all cells and the output register.

module priority_queue_bounded import pqb_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  pqb_in_if.sink   in_if,
  pqb_out_if.source out_if
);

  pqb_entry_t ent  [DEPTH];
  logic       disp [DEPTH];
  pqb_cmd_t   cmd;

  logic                     accept;
  logic                     full;
  logic [LVL_W-1:0]         lvl_sat;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     ovld_r;
  logic signed [DATA_W-1:0] odata_r, odata_nxt;
  logic [LVL_W-1:0]         olvl_r, olvl_nxt;
  logic [STAT_W-1:0]        ostat_r, ostat_nxt;

  localparam pqb_entry_t EMPTY_ENT = '0;

  assign in_if.ready = !ovld_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign full        = (cnt_r == CNT_W'(DEPTH));
  assign lvl_sat     = (in_if.level_in > LVL_MAX) ? LVL_MAX : in_if.level_in;

  assign cmd.enq   = accept && (in_if.opcode == OP_ENQ) && !full;
  assign cmd.deq   = accept && (in_if.opcode == OP_DEQ) && ent[0].used;
  assign cmd.level = lvl_sat;
  assign cmd.data  = in_if.data_in;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pqb_entry_t l_ent, r_ent;
    logic       l_disp;
    if (i == 0) begin : g_head
      assign l_ent  = EMPTY_ENT;
      assign l_disp = 1'b0;
    end else begin : g_mid
      assign l_ent  = ent[i-1];
      assign l_disp = disp[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r_ent = EMPTY_ENT;
    end else begin : g_body
      assign r_ent = ent[i+1];
    end
    pqb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_ent  (l_ent),
      .left_disp (l_disp),
      .right_ent (r_ent),
      .ent       (ent[i]),
      .disp      (disp[i])
    );
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    odata_nxt = '0;
    olvl_nxt  = '0;
    ostat_nxt = ST_OK;
    if (in_if.opcode == OP_ENQ) begin
      if (full) begin
        ostat_nxt = ST_FULL;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      if (!ent[0].used) begin
        ostat_nxt = ST_EMPTY;
      end else begin
        odata_nxt = ent[0].data;
        olvl_nxt  = ent[0].level;
        cnt_nxt   = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r  <= cnt_nxt;
        ovld_r <= 1'b1;
      end else if (out_if.ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      odata_r <= odata_nxt;
      olvl_r  <= olvl_nxt;
      ostat_r <= ostat_nxt;
    end
  end

  assign out_if.valid      = ovld_r;
  assign out_if.data_out   = odata_r;
  assign out_if.level_out  = olvl_r;
  assign out_if.status     = ostat_r;
  assign out_if.held_after = cnt_r;

endmodule

### design/pqb_checker.sv
`timescale 1ns / 1ps

module pqb_checker import pqb_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] data_out,
  input logic [LVL_W-1:0]         level_out,
  input logic [STAT_W-1:0]        status,
  input logic [CNT_W-1:0]         held_after
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(status)
      && $stable(held_after))
    else $error("result beat changed under stall");

  // every accepted beat yields a result the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat gave no result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> data_out == 0 && level_out == 0
      && held_after == 0)
    else $error("empty dequeue returned data");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> held_after <= CNT_W'(DEPTH) && level_out <= LVL_MAX)
    else $error("count or level out of range");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> held_after == CNT_W'(DEPTH))
    else $error("full reported below capacity");

endmodule

bind priority_queue_bounded pqb_checker u_pqb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .data_out   (out_if.data_out),
  .level_out  (out_if.level_out),
  .status     (out_if.status),
  .held_after (out_if.held_after)
);
